@@ rtl/lgs_pkg.sv @@
// shared constants, codes and types for the life grid generation step block
// no dependencies; every other file of the block imports this package
package lgs_pkg;

	// grid bounds
	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;
	localparam int MEM_AW   = $clog2(MAX_ROWS);

	// field widths
	localparam int CMD_W     = 2;
	localparam int ROW_W     = 6;
	localparam int COL_W     = 6;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;

	// command codes on the request channel
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_STEP  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 1'b1;

	localparam logic [CFG_W-1:0] CFG_ROWS_RESET = CFG_W'(64);
	localparam logic [CFG_W-1:0] CFG_COLS_RESET = CFG_W'(64);

	// rule b3/s23
	localparam logic [3:0] LIFE_BIRTH = 4'd3;
	localparam logic [3:0] LIFE_KEEP  = 4'd2;

	// command queue
	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_NOP,
		OP_WRITE,
		OP_READ,
		OP_STEP
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             value;
	} lgs_item_t;

	typedef struct packed {
		logic [CFG_W-1:0] rows;
		logic [CFG_W-1:0] cols;
	} lgs_size_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_READ,
		BK_PRIME,
		BK_ROW,
		BK_FINISH
	} bk_state_t;

endpackage

@@ rtl/lgs_ifs.sv @@
// request and result channel interfaces of the life grid block
// depends on lgs_pkg for field widths
interface lgs_cmd_if;
	import lgs_pkg::*;
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] command;
	logic [ROW_W-1:0] row_index;
	logic [COL_W-1:0] col_index;
	logic             cell_value;

	modport source(output valid, command, row_index, col_index, cell_value, input ready);
	modport sink(input valid, command, row_index, col_index, cell_value, output ready);
endinterface

interface lgs_res_if;
	logic valid;
	logic ready;
	logic read_value;
	logic step_done;

	modport source(output valid, read_value, step_done, input ready);
	modport sink(input valid, read_value, step_done, output ready);
endinterface

@@ rtl/lgs_front.sv @@
// front end: accepts requests, decodes and bounds-checks them into queue items
// depends on lgs_pkg and lgs_ifs
module lgs_front (
	input  logic              clk,
	input  logic              arst_n,
	input  lgs_pkg::lgs_size_t size,
	lgs_cmd_if.sink           cmd,
	output logic              push_valid,
	input  logic              push_ready,
	output lgs_pkg::lgs_item_t push_item
);
	import lgs_pkg::*;

	lgs_item_t item_d;
	lgs_item_t item_s1;
	logic      valid_s1;
	logic      in_area;

	assign in_area = (CFG_W'(cmd.row_index) < size.rows) && (CFG_W'(cmd.col_index) < size.cols);

	always_comb begin
		item_d.row   = cmd.row_index;
		item_d.col   = cmd.col_index;
		item_d.value = cmd.cell_value;
		unique case (cmd.command)
			CMD_WRITE: item_d.op = in_area ? OP_WRITE : OP_NOP;
			CMD_READ:  item_d.op = in_area ? OP_READ : OP_NOP;
			CMD_STEP:  item_d.op = OP_STEP;
			default:   item_d.op = OP_NOP;
		endcase
	end

	assign cmd.ready  = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.valid && cmd.ready) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1 <= item_d;
		end
	end

endmodule

@@ rtl/lgs_queue.sv @@
// short queue of decoded items between front end and back end
// depends on lgs_pkg
module lgs_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  lgs_pkg::lgs_item_t push_item,
	output logic              pop_valid,
	input  logic              pop,
	output lgs_pkg::lgs_item_t pop_item
);
	import lgs_pkg::*;

	lgs_item_t        slot_q [Q_DEPTH];
	logic [Q_AW-1:0]  wr_ptr_q;
	logic [Q_AW-1:0]  rd_ptr_q;
	logic [Q_CW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != Q_CW'(Q_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_item   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + Q_CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - Q_CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

@@ rtl/lgs_back.sv @@
// back end: grid memory, cell read/write and the row-by-row generation step
// depends on lgs_pkg and lgs_ifs
module lgs_back (
	input  logic              clk,
	input  logic              arst_n,
	input  lgs_pkg::lgs_size_t size,
	input  logic              q_valid,
	output logic              q_pop,
	input  lgs_pkg::lgs_item_t q_item,
	lgs_res_if.source         res
);
	import lgs_pkg::*;

	// next generation of one row from the masked old rows above, at and below
	function automatic logic [MAX_COLS-1:0] life_row(
		input logic [MAX_COLS-1:0] up,
		input logic [MAX_COLS-1:0] mid,
		input logic [MAX_COLS-1:0] dn
	);
		logic [MAX_COLS-1:0] upl, upr, mdl, mdr, dnl, dnr, nxt;
		logic [3:0]          n;
		upl = up << 1;
		upr = up >> 1;
		mdl = mid << 1;
		mdr = mid >> 1;
		dnl = dn << 1;
		dnr = dn >> 1;
		for (int c = 0; c < MAX_COLS; c++) begin
			n = 4'(upl[c]) + 4'(up[c]) + 4'(upr[c]) + 4'(mdl[c]) + 4'(mdr[c])
				+ 4'(dnl[c]) + 4'(dn[c]) + 4'(dnr[c]);
			nxt[c] = (n == LIFE_BIRTH) || (mid[c] && (n == LIFE_KEEP));
		end
		return nxt;
	endfunction

	logic [MAX_COLS-1:0] mem [MAX_ROWS];
	logic [MAX_ROWS-1:0] row_ok_q;
	logic [MAX_COLS-1:0] rd_q;
	logic                rd_ok_q;

	bk_state_t           state_q, state_d;
	lgs_item_t           item_q;
	logic [MEM_AW-1:0]   row_q;
	logic [MAX_COLS-1:0] upper_q;
	logic [MAX_COLS-1:0] cur_q;
	logic                res_read_q;
	logic                res_step_q;
	logic                out_valid_q;
	logic                out_read_q;
	logic                out_step_q;

	logic                mem_we;
	logic [MEM_AW-1:0]   mem_waddr;
	logic [MAX_COLS-1:0] mem_wmask;
	logic [MAX_COLS-1:0] mem_wdata;
	logic [MEM_AW-1:0]   mem_raddr;

	logic [MAX_COLS-1:0] rd_eff;
	logic [MAX_COLS-1:0] col_mask;
	logic [MAX_COLS-1:0] lower;
	logic [MAX_COLS-1:0] new_row;
	logic [MAX_COLS-1:0] cell_bit;
	logic                last_row;
	logic                out_load;

	// a row never written since reset reads as all dead
	assign rd_eff = rd_ok_q ? rd_q : '0;

	always_comb begin
		for (int c = 0; c < MAX_COLS; c++) begin
			col_mask[c] = CFG_W'(c) < size.cols;
		end
	end

	assign last_row = (CFG_W'(row_q) + CFG_W'(1)) == size.rows;
	assign lower    = last_row ? '0 : rd_eff;
	assign new_row  = (life_row(upper_q & col_mask, cur_q & col_mask, lower & col_mask) & col_mask)
		| (cur_q & ~col_mask);
	assign cell_bit = MAX_COLS'(1) << q_item.col;
	assign out_load = (state_q == BK_FINISH) && (!out_valid_q || res.ready);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					unique case (q_item.op)
						OP_READ:           state_d = BK_READ;
						OP_STEP:           state_d = (size.rows == '0) ? BK_FINISH : BK_PRIME;
						OP_NOP, OP_WRITE:  state_d = BK_FINISH;
					endcase
				end
			end
			BK_READ:   state_d = BK_FINISH;
			BK_PRIME:  state_d = BK_ROW;
			BK_ROW:    state_d = last_row ? BK_FINISH : BK_ROW;
			BK_FINISH: state_d = out_load ? BK_IDLE : BK_FINISH;
			default:   state_d = BK_IDLE;
		endcase
	end

	// memory port and queue control
	always_comb begin
		q_pop     = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = row_q;
		mem_wmask = '1;
		mem_wdata = new_row;
		mem_raddr = MEM_AW'(CFG_W'(row_q) + CFG_W'(2));
		unique case (state_q)
			BK_IDLE: begin
				q_pop = q_valid;
				if (q_valid) begin
					mem_raddr = MEM_AW'(q_item.row);
					if (q_item.op == OP_WRITE) begin
						mem_we    = 1'b1;
						mem_waddr = MEM_AW'(q_item.row);
						// a row not yet written is stored whole so its other cells read dead
						mem_wmask = row_ok_q[MEM_AW'(q_item.row)] ? cell_bit : '1;
						mem_wdata = {MAX_COLS{q_item.value}} & cell_bit;
					end else if (q_item.op == OP_STEP) begin
						mem_raddr = '0;
					end
				end
			end
			BK_PRIME: mem_raddr = MEM_AW'(1);
			BK_ROW:   mem_we    = 1'b1;
			BK_READ, BK_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			for (int b = 0; b < MAX_COLS; b++) begin
				if (mem_wmask[b]) begin
					mem[mem_waddr][b] <= mem_wdata[b];
				end
			end
		end
		rd_q    <= mem[mem_raddr];
		rd_ok_q <= row_ok_q[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_ok_q    <= '0;
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mem_we) begin
				row_ok_q[mem_waddr] <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					item_q     <= q_item;
					res_read_q <= 1'b0;
					res_step_q <= q_item.op == OP_STEP;
				end
			end
			BK_READ: res_read_q <= rd_eff[item_q.col];
			BK_PRIME: begin
				upper_q <= '0;
				cur_q   <= rd_eff;
				row_q   <= '0;
			end
			BK_ROW: begin
				upper_q <= cur_q;
				cur_q   <= rd_eff;
				row_q   <= row_q + MEM_AW'(1);
			end
			BK_FINISH: begin
				if (out_load) begin
					out_read_q <= res_read_q;
					out_step_q <= res_step_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign res.valid      = out_valid_q;
	assign res.read_value = out_read_q;
	assign res.step_done  = out_step_q;

endmodule

@@ rtl/life_grid_generation_step.sv @@
// top level of the life grid block: config registers, front end, queue, back end
// depends on lgs_pkg, lgs_ifs, lgs_front, lgs_queue and lgs_back
//
// channel  | dir | payload                                        | handshake
// ---------+-----+------------------------------------------------+-------------
// cmd      | in  | command, row_index, col_index, cell_value      | valid/ready
// res      | out | read_value, step_done                          | valid/ready
// cfg      | in  | cfg_index, cfg_wdata                           | cfg_we
//
// a write or no-op request occupies the back end in IDLE and FINISH, a read also in READ;
// a step passes PRIME, one ROW state per grid row in use and FINISH (only FINISH with no rows), one
// grid row rewritten per cycle through the single-write, single-read grid memory
// the front end and a two-deep queue keep taking requests while the back end works
// reset clears the per-row valid flags, so the grid reads all dead at once with no clearing pass
// a stalled result holds in the output register and stops the back end only at its last state
module life_grid_generation_step (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lgs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lgs_pkg::CFG_W-1:0]      cfg_wdata,
	lgs_cmd_if.sink                        cmd,
	lgs_res_if.source                      res
);
	import lgs_pkg::*;

	// configured size, clamped to the grid bounds
	logic [CFG_W-1:0] grid_rows_q;
	logic [CFG_W-1:0] grid_cols_q;
	lgs_size_t        size;

	// front end to queue
	logic      fr_valid;
	logic      fr_ready;
	lgs_item_t fr_item;

	// queue to back end
	logic      q_valid;
	logic      q_pop;
	lgs_item_t q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= CFG_ROWS_RESET;
			grid_cols_q <= CFG_COLS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GRID_ROWS: grid_rows_q <= cfg_wdata;
				CFG_GRID_COLS: grid_cols_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// sizes above the grid act as the full grid
	assign size.rows = (grid_rows_q > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : grid_rows_q;
	assign size.cols = (grid_cols_q > CFG_W'(MAX_COLS)) ? CFG_W'(MAX_COLS) : grid_cols_q;

	// decode and bounds check of each request
	lgs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.size       (size),
		.cmd        (cmd),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_item  (fr_item)
	);

	// decoupling queue
	lgs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_item  (fr_item),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_item   (q_item)
	);

	// grid memory and generation step engine, drives the result channel
	lgs_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.size    (size),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_item  (q_item),
		.res     (res)
	);

	// an accepted request always reaches the front end register
	a_front_capture: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> fr_valid)
		else $error("accepted request not held by front end");

	// the back end pops only what the queue holds
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty queue");

	// every item passes through at least one more back end state before the next pop
	a_pop_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> !q_pop)
		else $error("back end popped on consecutive cycles");

	// a result is never both a cell read and a finished step
	a_res_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> $onehot0({res.read_value, res.step_done}))
		else $error("result flags both read value and step done");

endmodule

@@ verif/tb.sv @@
// self-checking testbench for the life grid generation step block
// depends on lgs_pkg, lgs_ifs and the life_grid_generation_step rtl
`timescale 1ns / 1ps

module tb;
	import lgs_pkg::*;

	// command code the block leaves unused
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	// cycles with no accepted request or result before the run is called hung
	localparam int HANG_LIMIT = 3000;
	localparam int NUM_OPENING = 24;
	localparam int NUM_PHASES = 12;

	typedef struct packed {
		logic read_value;
		logic step_done;
	} life_result_t;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             value;
		logic             typed;   // expected result given by hand below
		life_result_t     result;
	} opening_req_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	lgs_cmd_if cmd_ch ();
	lgs_res_if res_ch ();

	life_grid_generation_step DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_ch),
		.res       (res_ch)
	);

	// our own copy of the grid and of the size registers
	logic [MAX_COLS-1:0] life_grid [MAX_ROWS];
	logic [CFG_W-1:0]    size_rows;
	logic [CFG_W-1:0]    size_cols;

	// results still owed by the block, oldest first
	life_result_t pending_results [$];

	// hand-typed result that rides along with the request on the wire
	logic         cur_typed;
	life_result_t cur_typed_result;

	bit idle_on;
	int mismatch_count;
	int quiet_cycles;

	// directed opening: reset contents, corners, cmd 3, a blinker and a corner block
	opening_req_t opening_requests [NUM_OPENING] = '{
		'{CMD_READ,   6'd0,  6'd0,  1'b0, 1'b1, 2'b00},  // grid reads dead after reset
		'{CMD_READ,   6'd63, 6'd63, 1'b0, 1'b1, 2'b00},
		'{CMD_WRITE,  6'd0,  6'd0,  1'b1, 1'b1, 2'b00},
		'{CMD_READ,   6'd0,  6'd0,  1'b0, 1'b1, 2'b10},
		'{CMD_WRITE,  6'd63, 6'd63, 1'b1, 1'b1, 2'b00},
		'{CMD_READ,   6'd63, 6'd63, 1'b0, 1'b1, 2'b10},
		'{CMD_WRITE,  6'd63, 6'd63, 1'b0, 1'b1, 2'b00},
		'{CMD_READ,   6'd63, 6'd63, 1'b0, 1'b1, 2'b00},
		'{CMD_UNUSED, 6'd63, 6'd63, 1'b1, 1'b1, 2'b00},  // unused command changes nothing
		'{CMD_READ,   6'd0,  6'd0,  1'b0, 1'b1, 2'b10},
		'{CMD_WRITE,  6'd10, 6'd9,  1'b1, 1'b1, 2'b00},
		'{CMD_WRITE,  6'd10, 6'd10, 1'b1, 1'b1, 2'b00},
		'{CMD_WRITE,  6'd10, 6'd11, 1'b1, 1'b1, 2'b00},
		'{CMD_STEP,   6'd0,  6'd0,  1'b0, 1'b1, 2'b01},
		'{CMD_READ,   6'd9,  6'd10, 1'b0, 1'b0, 2'b00},
		'{CMD_READ,   6'd10, 6'd9,  1'b0, 1'b0, 2'b00},
		'{CMD_READ,   6'd0,  6'd0,  1'b0, 1'b0, 2'b00},
		'{CMD_WRITE,  6'd62, 6'd62, 1'b1, 1'b1, 2'b00},
		'{CMD_WRITE,  6'd62, 6'd63, 1'b1, 1'b1, 2'b00},
		'{CMD_WRITE,  6'd63, 6'd62, 1'b1, 1'b1, 2'b00},
		'{CMD_STEP,   6'd63, 6'd63, 1'b1, 1'b1, 2'b01},
		'{CMD_READ,   6'd63, 6'd63, 1'b0, 1'b0, 2'b00},  // birth at the far corner
		'{CMD_READ,   6'd11, 6'd10, 1'b0, 1'b0, 2'b00},
		'{CMD_UNUSED, 6'd0,  6'd0,  1'b0, 1'b1, 2'b00}
	};

	// size settings walked by the random part; the first keeps the reset size
	// zero sizes and sizes above the maximum are in the list on purpose
	int phase_rows [NUM_PHASES] = '{64, 8, 1,  1, 64, 3, 0,  9, 127, 16, 5,  64};
	int phase_cols [NUM_PHASES] = '{64, 8, 1, 64,  1, 5, 17, 0, 100, 16, 64, 64};
	int phase_len  [NUM_PHASES] = '{200, 250, 80, 100, 100, 150, 40, 40, 120, 250, 150, 200};

	function automatic int rows_used();
		return (size_rows > MAX_ROWS) ? MAX_ROWS : int'(size_rows);
	endfunction

	function automatic int cols_used();
		return (size_cols > MAX_COLS) ? MAX_COLS : int'(size_cols);
	endfunction

	// one b3/s23 generation over the area in use; cells outside it stay put
	function automatic void next_generation();
		logic [MAX_COLS-1:0] prev [MAX_ROWS];
		int nr, nc, r, c, dr, dc, rr, cc, n;
		prev = life_grid;
		nr = rows_used();
		nc = cols_used();
		for (r = 0; r < nr; r++) begin
			for (c = 0; c < nc; c++) begin
				n = 0;
				for (dr = -1; dr <= 1; dr++) begin
					for (dc = -1; dc <= 1; dc++) begin
						rr = r + dr;
						cc = c + dc;
						// neighbours off the area count as dead, no wrap
						if ((dr != 0 || dc != 0) && rr >= 0 && rr < nr && cc >= 0 && cc < nc)
							n += prev[rr][cc];
					end
				end
				if (prev[r][c])
					life_grid[r][c] = (n == LIFE_KEEP) || (n == LIFE_BIRTH);
				else
					life_grid[r][c] = (n == LIFE_BIRTH);
			end
		end
	endfunction

	// apply one accepted request to our grid and return the result it owes
	function automatic life_result_t apply_request(logic [CMD_W-1:0] c, logic [ROW_W-1:0] r,
			logic [COL_W-1:0] col, logic v);
		life_result_t out;
		bit on_grid;
		out = '0;
		on_grid = (int'(r) < rows_used()) && (int'(col) < cols_used());
		case (c)
			CMD_WRITE: begin
				if (on_grid)
					life_grid[r][col] = v;
			end
			CMD_READ: begin
				if (on_grid)
					out.read_value = life_grid[r][col];
			end
			CMD_STEP: begin
				next_generation();
				out.step_done = 1'b1;
			end
			default: ;
		endcase
		return out;
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side back-pressure: random stall bursts, only while idle_on is set
	initial begin : ready_gen
		int stall_left;
		res_ch.ready = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 99) < 15) begin
				stall_left = $urandom_range(0, 3);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// request and result monitor, result checker and hang watchdog
	always @(posedge clk) begin : monitor
		life_result_t predicted;
		life_result_t want;
		bit moved;
		moved = 0;
		if (arst_n && cmd_ch.valid && cmd_ch.ready) begin
			moved = 1;
			predicted = apply_request(cmd_ch.command, cmd_ch.row_index, cmd_ch.col_index,
				cmd_ch.cell_value);
			// a hand-typed row takes its own result, the predictor still keeps the grid
			if (cur_typed)
				pending_results = {pending_results, cur_typed_result};
			else
				pending_results = {pending_results, predicted};
		end
		if (arst_n && res_ch.valid && res_ch.ready) begin
			moved = 1;
			if (pending_results.size() == 0) begin
				$error("result arrived with no request waiting");
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (res_ch.read_value !== want.read_value) begin
					$error("read_value expected %0d got %0d", want.read_value, res_ch.read_value);
					mismatch_count++;
				end
				if (res_ch.step_done !== want.step_done) begin
					$error("step_done expected %0d got %0d", want.step_done, res_ch.step_done);
					mismatch_count++;
				end
			end
		end
		if (arst_n) begin
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// present one request at a falling edge, hold it until taken; returns at a falling edge
	task automatic send_request(input logic [CMD_W-1:0] c, input logic [ROW_W-1:0] r,
			input logic [COL_W-1:0] col, input logic v, input logic typed,
			input life_result_t typed_result);
		int gap;
		if (idle_on && $urandom_range(0, 99) < 20) begin
			gap = $urandom_range(1, 4);
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.valid      <= 1'b1;
		cmd_ch.command    <= c;
		cmd_ch.row_index  <= r;
		cmd_ch.col_index  <= col;
		cmd_ch.cell_value <= v;
		cur_typed         = typed;
		cur_typed_result  = typed_result;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		@(negedge clk);
	endtask

	// stop sending and let every owed result come back, then settle for as many falling edges as settle asks
	task automatic drain_requests(input int settle);
		cmd_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	// new grid size, written while the block is idle
	task automatic write_size(input int rows, input int cols);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_GRID_ROWS;
		cfg_wdata <= CFG_W'(rows);
		size_rows = CFG_W'(rows);
		@(negedge clk);
		cfg_index <= CFG_GRID_COLS;
		cfg_wdata <= CFG_W'(cols);
		size_cols = CFG_W'(cols);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// random requests: mostly pattern writes and reads in a small window, with steps and unused commands mixed in
	task automatic run_phase(input int count);
		int k, p, er, ec, span_r, span_c, wr, wc;
		logic [CMD_W-1:0] c;
		logic [ROW_W-1:0] r;
		logic [COL_W-1:0] col;
		logic v;
		er = rows_used();
		ec = cols_used();
		span_r = (er == 0) ? 8 : ((er < 8) ? er : 8);
		span_c = (ec == 0) ? 8 : ((ec < 8) ? ec : 8);
		wr = 0;
		wc = 0;
		for (k = 0; k < count; k++) begin
			// halfway through, the sender holds off until the block has answered everything
			if (idle_on && k == count / 2)
				drain_requests(0);
			// move the window now and then: edges, corners and the middle
			if (k == 0 || $urandom_range(0, 99) < 3) begin
				case ($urandom_range(0, 2))
					0: wr = 0;
					1: wr = (er > 8) ? er - 8 : 0;
					default: wr = (er > 8) ? $urandom_range(0, er - 8) : 0;
				endcase
				case ($urandom_range(0, 2))
					0: wc = 0;
					1: wc = (ec > 8) ? ec - 8 : 0;
					default: wc = (ec > 8) ? $urandom_range(0, ec - 8) : 0;
				endcase
			end
			p = $urandom_range(0, 99);
			if (p < 50)
				c = CMD_WRITE;
			else if (p < 78)
				c = CMD_READ;
			else if (p < 94)
				c = CMD_STEP;
			else
				c = CMD_UNUSED;
			// some indexes anywhere, also beyond the area in use
			if ($urandom_range(0, 99) < 15) begin
				r   = ROW_W'($urandom_range(0, 63));
				col = COL_W'($urandom_range(0, 63));
			end else begin
				r   = ROW_W'(wr + $urandom_range(0, span_r - 1));
				col = COL_W'(wc + $urandom_range(0, span_c - 1));
			end
			v = ($urandom_range(0, 99) < 45);
			send_request(c, r, col, v, 1'b0, '0);
		end
	endtask

	initial begin : main
		int i, ph;
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = CFG_GRID_ROWS;
		cfg_wdata         = '0;
		cmd_ch.valid      = 1'b0;
		cmd_ch.command    = CMD_WRITE;
		cmd_ch.row_index  = '0;
		cmd_ch.col_index  = '0;
		cmd_ch.cell_value = 1'b0;
		cur_typed         = 1'b0;
		cur_typed_result  = '0;
		idle_on           = 1;
		mismatch_count    = 0;
		quiet_cycles      = 0;
		size_rows         = CFG_ROWS_RESET;
		size_cols         = CFG_COLS_RESET;
		for (i = 0; i < MAX_ROWS; i++)
			life_grid[i] = '0;

		// reset once, released at a falling edge
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (i = 0; i < NUM_OPENING; i++)
			send_request(opening_requests[i].command, opening_requests[i].row,
				opening_requests[i].col, opening_requests[i].value,
				opening_requests[i].typed, opening_requests[i].result);

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph > 0) begin
				drain_requests(8);
				write_size(phase_rows[ph], phase_cols[ph]);
			end
			// last setting runs flat out on both sides
			if (ph == NUM_PHASES - 1)
				idle_on = 0;
			run_phase(phase_len[ph]);
		end

		drain_requests(10);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
